FILE: hdl/deq_pkg.sv
// Shared codes, commands and defaults for the double-ended queue core.
package deq_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int WORD_BITS_DEF = 32;
    localparam int OP_BITS       = 2;
    localparam int STATUS_BITS   = 2;

    typedef enum logic [OP_BITS-1:0] {
        OP_PUSH_BACK  = 2'd0,
        OP_PUSH_FRONT = 2'd1,
        OP_POP_BACK   = 2'd2,
        OP_POP_FRONT  = 2'd3
    } deq_op_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } deq_status_t;

    // What every cell of one chain does on the next edge.
    typedef enum logic [1:0] {
        CMD_HOLD      = 2'd0,
        CMD_SHIFT_IN  = 2'd1,   // take the left neighbor's word, new word enters cell 0
        CMD_SHIFT_OUT = 2'd2,   // take the right neighbor's word, head leaves
        CMD_APPEND    = 2'd3    // the first free cell takes the new word
    } deq_cmd_t;

endpackage

FILE: hdl/double_ended_queue_core.sv
// Top level of the double-ended queue core: control, fill count and result register.
//
// A bounded deque of DEPTH signed words. Each item on the slave stream asks for
// one operation (push back, push front, pop back, pop front) and gives exactly one
// item on the master stream: the front and back words after the operation, the
// entry count and a status (done, pop on empty, push on full). An empty deque
// reads all ones (-1) at both ends. Storage is two mirrored rows of cells: the
// front row keeps the front word in its first cell, the back row keeps the same
// words in reverse order with the back word in its first cell. Every operation
// either shifts a whole row by one cell or drops a word into the first free cell.
// One item is accepted per cycle while the result slot is free or being emptied:
// the result is registered and shows in the cycle after acceptance, and a new item
// is taken in the same cycle the pending result is taken. No clearing pass is
// needed after reset; cells beyond the count are never shown.
module double_ended_queue_core #(
    parameter int DEPTH     = deq_pkg::DEPTH_DEF,
    parameter int WORD_BITS = deq_pkg::WORD_BITS_DEF,
    localparam int CW       = $clog2(DEPTH + 1),
    localparam int IN_W     = ((deq_pkg::OP_BITS + WORD_BITS + 7) / 8) * 8,
    localparam int OUT_W    = ((2 * WORD_BITS + CW + deq_pkg::STATUS_BITS + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // op, value
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // front_value, back_value, count, status
);

    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    deq_pkg::deq_op_t     op;
    logic [WORD_BITS-1:0] value;
    logic                 accept_in;

    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    deq_pkg::deq_status_t status_reg;
    deq_pkg::deq_status_t status_next;
    logic                 valid_reg;
    logic                 valid_next;

    deq_pkg::deq_cmd_t    sel_front;
    deq_pkg::deq_cmd_t    sel_back;
    deq_pkg::deq_cmd_t    cmd_front;
    deq_pkg::deq_cmd_t    cmd_back;

    logic [WORD_BITS-1:0] front_head;
    logic [WORD_BITS-1:0] back_head;
    logic [WORD_BITS-1:0] front_value;
    logic [WORD_BITS-1:0] back_value;
    logic                 is_empty;
    logic                 is_full;

    // unpack the request
    assign op    = deq_pkg::deq_op_t'(s_tdata[deq_pkg::OP_BITS-1:0]);
    assign value = s_tdata[deq_pkg::OP_BITS +: WORD_BITS];

    // take a new item whenever the result slot is free or being emptied
    assign s_tready  = !valid_reg || m_tready;
    assign accept_in = s_tvalid && s_tready;

    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == FULL_COUNT);

    // decode the operation into row commands, count and status
    always_comb
    begin
        sel_front   = deq_pkg::CMD_HOLD;
        sel_back    = deq_pkg::CMD_HOLD;
        count_next  = count_reg;
        status_next = deq_pkg::ST_DONE;
        case (op)
            deq_pkg::OP_PUSH_BACK:
            begin
                if (is_full)
                begin
                    status_next = deq_pkg::ST_FULL;
                end
                else
                begin
                    sel_front  = deq_pkg::CMD_APPEND;
                    sel_back   = deq_pkg::CMD_SHIFT_IN;
                    count_next = count_reg + CW'(1);
                end
            end
            deq_pkg::OP_PUSH_FRONT:
            begin
                if (is_full)
                begin
                    status_next = deq_pkg::ST_FULL;
                end
                else
                begin
                    sel_front  = deq_pkg::CMD_SHIFT_IN;
                    sel_back   = deq_pkg::CMD_APPEND;
                    count_next = count_reg + CW'(1);
                end
            end
            deq_pkg::OP_POP_BACK:
            begin
                if (is_empty)
                begin
                    status_next = deq_pkg::ST_EMPTY;
                end
                else
                begin
                    // front row just loses its tail through the count
                    sel_back   = deq_pkg::CMD_SHIFT_OUT;
                    count_next = count_reg - CW'(1);
                end
            end
            deq_pkg::OP_POP_FRONT:
            begin
                if (is_empty)
                begin
                    status_next = deq_pkg::ST_EMPTY;
                end
                else
                begin
                    sel_front  = deq_pkg::CMD_SHIFT_OUT;
                    count_next = count_reg - CW'(1);
                end
            end
            default:
            begin
                status_next = deq_pkg::ST_DONE;
            end
        endcase
    end

    // rows only move on an accepted item
    assign cmd_front = accept_in ? sel_front : deq_pkg::CMD_HOLD;
    assign cmd_back  = accept_in ? sel_back  : deq_pkg::CMD_HOLD;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept_in)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            status_reg <= deq_pkg::ST_DONE;
            valid_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (accept_in)
            begin
                count_reg  <= count_next;
                status_reg <= status_next;
            end
        end
    end

    // front row: front word in cell 0
    deq_chain #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS),
        .CW        (CW)
    ) u_front_row (
        .clk   (clk),
        .cmd   (cmd_front),
        .count (count_reg),
        .value (value),
        .head  (front_head)
    );

    // back row: same words reversed, back word in cell 0
    deq_chain #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS),
        .CW        (CW)
    ) u_back_row (
        .clk   (clk),
        .cmd   (cmd_back),
        .count (count_reg),
        .value (value),
        .head  (back_head)
    );

    // heads hold still while the result waits, since rows move only on accept
    assign front_value = is_empty ? '1 : front_head;
    assign back_value  = is_empty ? '1 : back_head;

    assign m_tvalid = valid_reg;
    assign m_tdata  = OUT_W'({status_reg, count_reg, back_value, front_value});

    // count never runs past the capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("deque count above capacity");

    // a rejected push leaves the count alone
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        accept_in && is_full && (op == deq_pkg::OP_PUSH_BACK || op == deq_pkg::OP_PUSH_FRONT)
        |=> $stable(count_reg) && status_reg == deq_pkg::ST_FULL)
        else $error("push on full deque changed the count");

    // a good push grows the count by one
    a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
        accept_in && !is_full && (op == deq_pkg::OP_PUSH_BACK || op == deq_pkg::OP_PUSH_FRONT)
        |=> count_reg == $past(count_reg) + CW'(1))
        else $error("push did not advance the count");

    // every accepted item leaves a result
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept_in |=> m_tvalid)
        else $error("accepted item produced no result");

    // an empty report comes only with an empty deque
    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && status_reg == deq_pkg::ST_EMPTY |-> count_reg == '0)
        else $error("empty status with entries held");

endmodule

FILE: hdl/deq_cell.sv
// One storage cell of a deque chain: holds one word and trades it with its neighbors.
module deq_cell #(
    parameter int WORD_BITS = deq_pkg::WORD_BITS_DEF,
    parameter int CW        = 5,
    parameter int IDX       = 0
) (
    input  logic                 clk,
    input  deq_pkg::deq_cmd_t    cmd,
    input  logic [CW-1:0]        count,
    input  logic [WORD_BITS-1:0] value,
    input  logic [WORD_BITS-1:0] left_data,
    input  logic [WORD_BITS-1:0] right_data,
    output logic [WORD_BITS-1:0] data
);

    localparam logic [CW-1:0] SLOT = CW'(IDX);

    logic [WORD_BITS-1:0] data_reg;
    logic [WORD_BITS-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (cmd)
            deq_pkg::CMD_HOLD:      data_next = data_reg;
            deq_pkg::CMD_SHIFT_IN:  data_next = left_data;
            deq_pkg::CMD_SHIFT_OUT: data_next = right_data;
            deq_pkg::CMD_APPEND:
            begin
                // first free slot sits at index count
                if (count == SLOT)
                begin
                    data_next = value;
                end
            end
            default:                data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

FILE: hdl/deq_chain.sv
// A row of deque cells with its head at cell 0; words move one cell per cycle while the row shifts.
module deq_chain #(
    parameter int DEPTH     = deq_pkg::DEPTH_DEF,
    parameter int WORD_BITS = deq_pkg::WORD_BITS_DEF,
    parameter int CW        = 5
) (
    input  logic                 clk,
    input  deq_pkg::deq_cmd_t    cmd,
    input  logic [CW-1:0]        count,
    input  logic [WORD_BITS-1:0] value,
    output logic [WORD_BITS-1:0] head
);

    logic [WORD_BITS-1:0] cell_data [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [WORD_BITS-1:0] left_w;
        logic [WORD_BITS-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = value;
        end
        else
        begin : g_mid_l
            assign left_w = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_w = cell_data[i];
        end
        else
        begin : g_mid_r
            assign right_w = cell_data[i+1];
        end

        deq_cell #(
            .WORD_BITS (WORD_BITS),
            .CW        (CW),
            .IDX       (i)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .count      (count),
            .value      (value),
            .left_data  (left_w),
            .right_data (right_w),
            .data       (cell_data[i])
        );
    end

    assign head = cell_data[0];

endmodule
